FILE: src/osf_pkg.sv
`timescale 1ns / 1ps
package osf_pkg;
  localparam int unsigned BlockSizeDef = 8;
  localparam int unsigned NumTaps      = 7;
  localparam int unsigned SampleW      = 16;
  localparam int unsigned OutW         = 20;
  localparam int unsigned CfgIdxW      = 3;
  localparam int unsigned CfgDataW     = 16;
  localparam int unsigned AccW         = 36;

  localparam logic [CfgIdxW-1:0] RegTapCount = 3'd0;
endpackage

FILE: src/osf_if.sv
`timescale 1ns / 1ps
interface osf_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [osf_pkg::SampleW-1:0]  sample_in;
  modport source (output valid, output sample_in, input ready);
  modport sink   (input valid, input sample_in, output ready);
endinterface

interface osf_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [osf_pkg::OutW-1:0]     filtered_sample;
  logic                                last_of_block;
  modport source (output valid, output filtered_sample, output last_of_block, input ready);
  modport sink   (input valid, input filtered_sample, input last_of_block, output ready);
endinterface

FILE: src/osf_mac.sv
`timescale 1ns / 1ps
// While en_i is high, one tap product per cycle into an accumulator; floor shift and saturation at the end.
module osf_mac (
  input  logic                               clk_i,
  input  logic                               clear_i,
  input  logic                               en_i,
  input  logic signed [osf_pkg::SampleW-1:0] tap_i,
  input  logic signed [osf_pkg::SampleW-1:0] smp_i,
  output logic signed [osf_pkg::OutW-1:0]    result_o
);
  localparam int unsigned AccW = osf_pkg::AccW;
  localparam int unsigned OutW = osf_pkg::OutW;
  logic signed [AccW-1:0] acc_q, acc_d;
  logic signed [AccW-1:0] shifted;

  always_comb begin
    acc_d = acc_q;
    if (clear_i) acc_d = '0;
    else if (en_i) acc_d = acc_q + AccW'(tap_i * smp_i);
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
  end

  assign shifted = acc_q >>> 15;
  always_comb begin
    if (shifted > AccW'(signed'(524287))) result_o = OutW'(524287);
    else if (shifted < -AccW'(signed'(524288))) result_o = OutW'(-524288);
    else result_o = OutW'(shifted);
  end
endmodule

FILE: src/overlap_save_fir_filter.sv
`timescale 1ns / 1ps
// Channel   | Dir | Payload
// in_if     | in  | sample_in (16b signed)
// out_if    | out | filtered_sample (20b signed), last_of_block
// cfg       | in  | cfg_we_i / cfg_idx_i / cfg_data_i, index 0 tap_count, 1..7 taps
//
// An input beat writes the window memory. When a block completes,
// L = BLOCK_SIZE - m outputs follow; each passes through the MAC
// (one window memory read and one product per cycle), a drain state and an output beat.
// Input is held off while a burst is computed or an output waits.
// Reset clears the write pointer, fill count and window valid bits (no sweep).
// Output stalls hold the burst sequencer.
module overlap_save_fir_filter #(
  parameter int unsigned BLOCK_SIZE = osf_pkg::BlockSizeDef
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [osf_pkg::CfgIdxW-1:0]         cfg_idx_i,
  input  logic [osf_pkg::CfgDataW-1:0]        cfg_data_i,
  osf_in_if.sink                              in_if,
  osf_out_if.source                           out_if
);
  localparam int unsigned PtrW = $clog2(BLOCK_SIZE);
  localparam int unsigned SW   = osf_pkg::SampleW;

  typedef enum logic [1:0] {StIdle, StMac, StDrain, StOut} state_e;
  state_e state_q;

  logic [2:0] tap_count_q;
  logic signed [SW-1:0] taps_q [osf_pkg::NumTaps];

  // window memory, circular; ptr_q points at the oldest entry
  logic [SW-1:0] win_mem [BLOCK_SIZE];
  logic [BLOCK_SIZE-1:0] wvalid_q;
  logic [PtrW-1:0] ptr_q;
  logic [2:0] fill_q;
  logic [2:0] pos_q, j_q, m_q;
  logic [SW-1:0] rd_q;
  logic rd_ok_q, rd_en_q;
  logic [2:0] rd_j_q;
  logic last_q;

  logic [2:0] m_eff, len;
  always_comb begin
    m_eff = (tap_count_q == 3'd0) ? 3'd1 : tap_count_q;
    if (32'(m_eff) > BLOCK_SIZE - 1) m_eff = 3'(BLOCK_SIZE - 1);
    len = 3'(BLOCK_SIZE - 32'(m_eff));
  end

  assign in_if.ready = (state_q == StIdle);
  wire in_fire = in_if.valid && in_if.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tap_count_q <= 3'd1;
      for (int i = 0; i < osf_pkg::NumTaps; i++) taps_q[i] <= '0;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == osf_pkg::RegTapCount) tap_count_q <= cfg_data_i[2:0];
      else taps_q[cfg_idx_i - 3'd1] <= signed'(cfg_data_i);
    end
  end

  // window position p maps to address ptr+p (mod BLOCK_SIZE); p = pos - j
  logic [2:0] rd_pos;
  logic [PtrW-1:0] rd_addr;
  logic [31:0] rd_sum;
  assign rd_pos  = pos_q - j_q;
  assign rd_sum  = 32'(ptr_q) + 32'(rd_pos);
  assign rd_addr = PtrW'((rd_sum >= BLOCK_SIZE) ? rd_sum - BLOCK_SIZE : rd_sum);

  always_ff @(posedge clk_i) begin
    if (in_fire) win_mem[ptr_q] <= in_if.sample_in;
    rd_q <= win_mem[rd_addr];
  end

  logic signed [osf_pkg::OutW-1:0] mac_res;
  logic mac_clear;
  assign mac_clear = (state_q == StIdle) || (state_q == StOut && out_if.ready);
  osf_mac u_mac (
    .clk_i, .clear_i(mac_clear),
    .en_i(rd_en_q && rd_ok_q),
    .tap_i(taps_q[rd_j_q]),
    .smp_i(signed'(rd_q)),
    .result_o(mac_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle; ptr_q <= '0; fill_q <= '0; wvalid_q <= '0;
      pos_q <= '0; j_q <= '0; m_q <= '0; rd_ok_q <= 1'b0; rd_en_q <= 1'b0;
      rd_j_q <= '0; last_q <= 1'b0;
    end else begin
      rd_en_q <= 1'b0;
      unique case (state_q)
        StIdle: begin
          if (in_fire) begin
            wvalid_q[ptr_q] <= 1'b1;
            ptr_q <= (32'(ptr_q) == BLOCK_SIZE - 1) ? '0 : ptr_q + PtrW'(1);
            if (fill_q + 3'd1 >= len) begin
              fill_q <= '0; m_q <= m_eff; pos_q <= m_eff; j_q <= '0;
              state_q <= StMac;
            end else begin
              fill_q <= fill_q + 3'd1;
            end
          end
        end
        StMac: begin
          rd_en_q <= (j_q <= pos_q);
          rd_ok_q <= wvalid_q[rd_addr];
          rd_j_q <= j_q;
          if (j_q == m_q - 3'd1) state_q <= StDrain;
          else j_q <= j_q + 3'd1;
        end
        StDrain: begin
          last_q  <= (32'(pos_q) == BLOCK_SIZE - 1);
          state_q <= StOut;
        end
        StOut: begin
          if (out_if.ready) begin
            if (last_q) state_q <= StIdle;
            else begin
              pos_q <= pos_q + 3'd1; j_q <= '0; state_q <= StMac;
            end
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  assign out_if.valid           = (state_q == StOut);
  assign out_if.filtered_sample = mac_res;
  assign out_if.last_of_block   = last_q;

`ifndef SYNTHESIS
  a_no_in_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != StIdle) |-> !in_if.ready) else $error("input taken mid burst");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_if.valid && !out_if.ready) |=> out_if.valid && $stable(out_if.filtered_sample))
    else $error("result dropped");
  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_if.valid && out_if.ready && out_if.last_of_block) |=> state_q == StIdle)
    else $error("burst did not end");
`endif
endmodule
